FILE: design/csev_pkg.sv
// Shared constants and the command type for the clamped spline evaluator.
// No dependencies; imported by the front, back and top level.
`default_nettype none
package csev_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int KA_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CA_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    localparam logic       ACTION_WRITE = 1'b0;
    localparam logic       ACTION_EVAL  = 1'b1;

    localparam logic [1:0] KIND_EVAL       = 2'd0;
    localparam logic [1:0] KIND_WRITE_ALL  = 2'd1;
    localparam logic [1:0] KIND_WRITE_KNOT = 2'd2;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_FIRST  = 2'd1;
    localparam logic [1:0] REGION_LAST   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [KA_W-1:0]   index;
        logic [31:0]       knot;
        logic [31:0]       coef_a;
        logic [31:0]       coef_b;
        logic [31:0]       coef_c;
        logic [31:0]       coef_d;
        logic [31:0]       query;
    } csev_cmd_t;

    typedef struct packed {
        logic valid;
    } csev_q_ctrl_t;

endpackage
`default_nettype wire

FILE: design/clamped_spline_evaluator_top.sv
// Top level of the clamped spline evaluator: segment count register,
// front queue and back end. Depends on csev_pkg, csev_front and csev_back.
`default_nettype none
// A write beat stores one knot time and the four Q16.16 coefficients of
// that segment; an index of 16 stores the knot alone and larger indices
// are dropped. An evaluate beat returns one result beat. The back end's
// sequencer reads the first knot and, for a query after it, the last
// knot; a query inside the table then searches the knot RAM, one read per
// segment searched. Every query not at or before the first knot ends with
// five passes through the single 32x32 multiplier. The two-beat input
// queue and the output register let either side stall without blocking
// the other.
// segment_count may only be written while no evaluation is in flight.
module clamped_spline_evaluator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_enable,
    input  logic [4:0]  write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [4:0]  entry_index,
    input  logic [31:0] knot_time,
    input  logic [31:0] coef_const,
    input  logic [31:0] coef_linear,
    input  logic [31:0] coef_square,
    input  logic [31:0] coef_cube,
    input  logic [31:0] query_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic [1:0]  region,
    output logic        saturated
);
    import csev_pkg::*;

    logic [4:0]   segment_count_reg;
    csev_cmd_t    head;
    csev_q_ctrl_t q_ctrl;
    logic         head_valid;
    logic         head_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= 5'd1;
        end
        else if (write_enable)
        begin
            segment_count_reg <= write_data;
        end
    end

    csev_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .entry_index (entry_index),
        .knot_time   (knot_time),
        .coef_const  (coef_const),
        .coef_linear (coef_linear),
        .coef_square (coef_square),
        .coef_cube   (coef_cube),
        .query_time  (query_time),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop)
    );

    always_comb
    begin
        q_ctrl.valid = head_valid;
    end

    csev_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .segment_count (segment_count_reg),
        .head          (head),
        .q_in          (q_ctrl),
        .head_pop      (head_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .region        (region),
        .saturated     (saturated)
    );

endmodule
`default_nettype wire

FILE: design/csev_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: design/csev_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on csev_pkg.
`default_nettype none
module csev_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [4:0]            entry_index,
    input  logic [31:0]           knot_time,
    input  logic [31:0]           coef_const,
    input  logic [31:0]           coef_linear,
    input  logic [31:0]           coef_square,
    input  logic [31:0]           coef_cube,
    input  logic [31:0]           query_time,
    output csev_pkg::csev_cmd_t   head,
    output logic                  head_valid,
    input  logic                  head_pop
);
    import csev_pkg::*;

    csev_cmd_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    csev_cmd_t  cmd;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb
    begin
        cmd.index  = KA_W'(entry_index);
        cmd.knot   = knot_time;
        cmd.coef_a = coef_const;
        cmd.coef_b = coef_linear;
        cmd.coef_c = coef_square;
        cmd.coef_d = coef_cube;
        cmd.query  = query_time;
        keep       = 1'b1;
        if (action == ACTION_EVAL)
        begin
            cmd.kind = KIND_EVAL;
        end
        else if (32'(entry_index) < MAX_SEGMENTS)
        begin
            cmd.kind = KIND_WRITE_ALL;
        end
        else if (32'(entry_index) == MAX_SEGMENTS)
        begin
            cmd.kind = KIND_WRITE_KNOT;
        end
        else
        begin
            cmd.kind = KIND_WRITE_KNOT;
            keep     = 1'b0;
        end
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall && keep;
    assign pop        = head_pop && (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule
`default_nettype wire

FILE: design/csev_back.sv
// Back end: applies table writes, runs the knot search and the cubic
// evaluation on one shared multiplier, and holds the result beat.
// Depends on csev_pkg and csev_ram.
`default_nettype none
module csev_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [4:0]            segment_count,
    input  csev_pkg::csev_cmd_t   head,
    input  csev_pkg::csev_q_ctrl_t q_in,
    output logic                  head_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           value,
    output logic [1:0]            region,
    output logic                  saturated
);
    import csev_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_K0    = 4'd1;
    localparam logic [3:0] ST_KN    = 4'd2;
    localparam logic [3:0] ST_SRCH  = 4'd3;
    localparam logic [3:0] ST_KNM1  = 4'd4;
    localparam logic [3:0] ST_FIRST = 4'd5;
    localparam logic [3:0] ST_COEF  = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_SHIFT = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic [2:0] STEP_DT2 = 3'd0;
    localparam logic [2:0] STEP_LIN = 3'd1;
    localparam logic [2:0] STEP_DT3 = 3'd2;
    localparam logic [2:0] STEP_SQR = 3'd3;
    localparam logic [2:0] STEP_CUB = 3'd4;

    logic [3:0]         state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [CA_W-1:0]    idx_reg, idx_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] kn_reg, kn_next;
    logic signed [31:0] dt_reg, dt_next;
    logic signed [31:0] dt2_reg, dt2_next;
    logic signed [31:0] dt3_reg, dt3_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [33:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               flag_reg, flag_next;
    logic [1:0]         rgn_reg, rgn_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        value_reg, value_next;
    logic [1:0]         region_reg, region_next;
    logic               sat_reg, sat_next;

    logic [KA_W-1:0]    n_eff;
    logic [CA_W-1:0]    n_m1;
    logic [KA_W-1:0]    knot_raddr;
    logic [CA_W-1:0]    coef_raddr;
    logic signed [31:0] knot_rdata;
    logic [127:0]       coef_rdata;
    logic               knot_we;
    logic               coef_we;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] prod_sh;
    logic signed [31:0] prod_sat;
    logic               prod_ovf;
    logic signed [32:0] dt_exact;
    logic signed [31:0] dt_sat;
    logic               dt_ovf;
    logic               acc_ovf;
    logic signed [31:0] acc_sat;

    csev_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (head.index),
        .wdata (head.knot),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    csev_ram #(.WIDTH(128), .DEPTH(MAX_SEGMENTS)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (CA_W'(head.index)),
        .wdata ({head.coef_d, head.coef_c, head.coef_b, head.coef_a}),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    always_comb
    begin
        if (segment_count == 5'd0)
        begin
            n_eff = KA_W'(1);
        end
        else if (32'(segment_count) > MAX_SEGMENTS)
        begin
            n_eff = KA_W'(MAX_SEGMENTS);
        end
        else
        begin
            n_eff = KA_W'(segment_count);
        end
        n_m1 = CA_W'(n_eff - KA_W'(1));
    end

    // shared multiplier operands by step
    always_comb
    begin
        case (step_reg)
            STEP_DT2:
            begin
                op_a = dt_reg;
                op_b = dt_reg;
            end
            STEP_LIN:
            begin
                op_a = b_reg;
                op_b = dt_reg;
            end
            STEP_DT3:
            begin
                op_a = dt2_reg;
                op_b = dt_reg;
            end
            STEP_SQR:
            begin
                op_a = c_reg;
                op_b = dt2_reg;
            end
            default:
            begin
                op_a = d_reg;
                op_b = dt3_reg;
            end
        endcase
    end

    always_comb
    begin
        prod_sh  = prod_reg >>> FRAC_BITS;
        prod_ovf = (prod_sh[63:31] != {33{1'b0}}) && (prod_sh[63:31] != {33{1'b1}});
        if (!prod_ovf)
        begin
            prod_sat = prod_sh[31:0];
        end
        else if (prod_sh[63])
        begin
            prod_sat = 32'sh8000_0000;
        end
        else
        begin
            prod_sat = 32'sh7fff_ffff;
        end

        acc_ovf = (acc_reg[33:31] != 3'b000) && (acc_reg[33:31] != 3'b111);
        if (!acc_ovf)
        begin
            acc_sat = acc_reg[31:0];
        end
        else if (acc_reg[33])
        begin
            acc_sat = 32'sh8000_0000;
        end
        else
        begin
            acc_sat = 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        if (state_reg == ST_KNM1)
        begin
            dt_exact = 33'(kn_reg) - 33'(knot_rdata);
        end
        else
        begin
            dt_exact = 33'(t_reg) - 33'(prev_reg);
        end
        dt_ovf = (dt_exact[32] != dt_exact[31]);
        if (!dt_ovf)
        begin
            dt_sat = dt_exact[31:0];
        end
        else if (dt_exact[32])
        begin
            dt_sat = 32'sh8000_0000;
        end
        else
        begin
            dt_sat = 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        t_next         = t_reg;
        prev_next      = prev_reg;
        kn_next        = kn_reg;
        dt_next        = dt_reg;
        dt2_next       = dt2_reg;
        dt3_next       = dt3_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        flag_next      = flag_reg;
        rgn_next       = rgn_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        region_next    = region_reg;
        sat_next       = sat_reg;
        knot_raddr     = KA_W'(0);
        coef_raddr     = CA_W'(0);
        knot_we        = 1'b0;
        coef_we        = 1'b0;
        head_pop       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    head_pop = 1'b1;
                    case (head.kind)
                        KIND_EVAL:
                        begin
                            t_next     = head.query;
                            knot_raddr = KA_W'(0);
                            state_next = ST_K0;
                        end
                        KIND_WRITE_ALL:
                        begin
                            knot_we = 1'b1;
                            coef_we = 1'b1;
                        end
                        default:
                        begin
                            knot_we = 1'b1;
                        end
                    endcase
                end
            end
            ST_K0:
            begin
                prev_next = knot_rdata;
                if (t_reg <= knot_rdata)
                begin
                    rgn_next   = REGION_FIRST;
                    coef_raddr = CA_W'(0);
                    state_next = ST_FIRST;
                end
                else
                begin
                    knot_raddr = n_eff;
                    state_next = ST_KN;
                end
            end
            ST_KN:
            begin
                if (t_reg >= knot_rdata)
                begin
                    rgn_next   = REGION_LAST;
                    kn_next    = knot_rdata;
                    knot_raddr = KA_W'(n_m1);
                    state_next = ST_KNM1;
                end
                else
                begin
                    rgn_next   = REGION_INSIDE;
                    idx_next   = CA_W'(0);
                    knot_raddr = KA_W'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (t_reg < knot_rdata)
                begin
                    dt_next    = dt_sat;
                    flag_next  = dt_ovf;
                    coef_raddr = idx_reg;
                    state_next = ST_COEF;
                end
                else
                begin
                    prev_next  = knot_rdata;
                    idx_next   = idx_reg + CA_W'(1);
                    knot_raddr = KA_W'(idx_reg) + KA_W'(2);
                end
            end
            ST_KNM1:
            begin
                dt_next    = dt_sat;
                flag_next  = dt_ovf;
                coef_raddr = n_m1;
                state_next = ST_COEF;
            end
            ST_FIRST:
            begin
                acc_next   = 34'(signed'(coef_rdata[31:0]));
                flag_next  = 1'b0;
                state_next = ST_DONE;
            end
            ST_COEF:
            begin
                acc_next   = 34'(signed'(coef_rdata[31:0]));
                b_next     = coef_rdata[63:32];
                c_next     = coef_rdata[95:64];
                d_next     = coef_rdata[127:96];
                step_next  = STEP_DT2;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = op_a * op_b;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                flag_next  = flag_reg || prod_ovf;
                step_next  = step_reg + 3'd1;
                state_next = ST_MUL;
                case (step_reg)
                    STEP_DT2:
                    begin
                        dt2_next = prod_sat;
                    end
                    STEP_DT3:
                    begin
                        dt3_next = prod_sat;
                    end
                    STEP_CUB:
                    begin
                        acc_next   = acc_reg + 34'(prod_sat);
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        acc_next = acc_reg + 34'(prod_sat);
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = acc_sat;
                    region_next    = rgn_reg;
                    sat_next       = flag_reg || acc_ovf;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_DT2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        t_reg      <= t_next;
        prev_reg   <= prev_next;
        kn_reg     <= kn_next;
        dt_reg     <= dt_next;
        dt2_reg    <= dt2_next;
        dt3_reg    <= dt3_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        flag_reg   <= flag_next;
        rgn_reg    <= rgn_next;
        value_reg  <= value_next;
        region_reg <= region_next;
        sat_reg    <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign region    = region_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

FILE: design/csev_checker.sv
// Port-level checker for the clamped spline evaluator, bound to the top.
// Depends on csev_pkg for the region codes.
`default_nettype none
module csev_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value,
    input logic [1:0]  region,
    input logic        saturated
);
    import csev_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(region)
            && $stable(saturated))
        else $error("result beat changed while stalled");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (region == REGION_INSIDE) || (region == REGION_FIRST)
            || (region == REGION_LAST))
        else $error("undefined region code");

    a_first_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == REGION_FIRST) |-> !saturated)
        else $error("saturation flagged on first-knot result");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat shown during reset");

endmodule

bind clamped_spline_evaluator_top csev_checker u_csev_checker (.*);
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for clamped_spline_evaluator_top: a directed table, then random phases;
// each result beat is checked against a spline predictor kept in the bench or a value set in its row.
// Depends on csev_pkg and the design sources; needs no files or arguments.
module tb_top;
    import csev_pkg::*;

    localparam int     DRAIN_CYCLES = 40;
    localparam int     PHASES       = 8;
    localparam int     PHASE_BEATS  = 88;
    localparam int     END_WAIT     = 5000;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    typedef enum logic [1:0] {ROW_BEAT, ROW_CFG, ROW_LOAD} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        act;
        logic [4:0]  idx;
        logic [31:0] knot;
        logic [31:0] ca;
        logic [31:0] cb;
        logic [31:0] cc;
        logic [31:0] cd;
        logic [31:0] q;
        logic        typed;
        logic [31:0] tv;
        logic [1:0]  tr;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  region;
        logic        sat;
    } spline_res_t;

    logic        clk;
    logic        rst_n;
    logic        write_enable;
    logic [4:0]  write_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [4:0]  entry_index;
    logic [31:0] knot_time;
    logic [31:0] coef_const;
    logic [31:0] coef_linear;
    logic [31:0] coef_square;
    logic [31:0] coef_cube;
    logic [31:0] query_time;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic [1:0]  region;
    logic        saturated;

    int          knot_tab [0:MAX_SEGMENTS];
    int          a_tab    [0:MAX_SEGMENTS-1];
    int          b_tab    [0:MAX_SEGMENTS-1];
    int          c_tab    [0:MAX_SEGMENTS-1];
    int          d_tab    [0:MAX_SEGMENTS-1];
    logic [4:0]  seg_reg;

    spline_res_t pending_values [$];
    stim_row_t   dir_rows [$];
    int          mismatches;
    int          results_seen;
    int          burst_left;
    bit          no_gaps;

    clamped_spline_evaluator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .entry_index  (entry_index),
        .knot_time    (knot_time),
        .coef_const   (coef_const),
        .coef_linear  (coef_linear),
        .coef_square  (coef_square),
        .coef_cube    (coef_cube),
        .query_time   (query_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .region       (region),
        .saturated    (saturated)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ---- spline predictor ----

    function automatic int clip32(longint v, inout bit ovf);
        if (v > S32_MAX)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < S32_MIN)
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return int'(v);
    endfunction

    function automatic int qmul(int x, int y, inout bit ovf);
        longint p;
        p = longint'(x) * longint'(y);
        return clip32(p >>> FRAC_BITS, ovf);
    endfunction

    function automatic int eval_segment(int seg, longint dt_exact, inout bit ovf);
        int     dt;
        int     dt2;
        int     dt3;
        longint acc;
        dt  = clip32(dt_exact, ovf);
        dt2 = qmul(dt, dt, ovf);
        dt3 = qmul(dt2, dt, ovf);
        acc = longint'(a_tab[seg]) + longint'(qmul(b_tab[seg], dt, ovf))
            + longint'(qmul(c_tab[seg], dt2, ovf)) + longint'(qmul(d_tab[seg], dt3, ovf));
        return clip32(acc, ovf);
    endfunction

    function automatic int live_segments();
        if (seg_reg == 5'd0)
            return 1;
        if (seg_reg > MAX_SEGMENTS)
            return MAX_SEGMENTS;
        return int'(seg_reg);
    endfunction

    function automatic spline_res_t spline_value(logic [31:0] q);
        spline_res_t r;
        int          n;
        int          t;
        int          i;
        bit          ovf;
        bit          found;
        n        = live_segments();
        t        = int'(q);
        ovf      = 1'b0;
        found    = 1'b0;
        r.value  = '0;
        r.region = REGION_INSIDE;
        if (t <= knot_tab[0])
        begin
            r.region = REGION_FIRST;
            r.value  = a_tab[0];
        end
        else if (t >= knot_tab[n])
        begin
            r.region = REGION_LAST;
            r.value  = eval_segment(n - 1, longint'(knot_tab[n]) - longint'(knot_tab[n-1]), ovf);
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                if (!found && t < knot_tab[i+1])
                begin
                    found   = 1'b1;
                    r.value = eval_segment(i, longint'(t) - longint'(knot_tab[i]), ovf);
                end
            end
        end
        r.sat = ovf;
        return r;
    endfunction

    function automatic void record_beat(stim_row_t row);
        spline_res_t r;
        if (row.act == ACTION_WRITE)
        begin
            if (row.idx <= MAX_SEGMENTS)
            begin
                knot_tab[row.idx] = int'(row.knot);
                if (row.idx < MAX_SEGMENTS)
                begin
                    a_tab[row.idx] = int'(row.ca);
                    b_tab[row.idx] = int'(row.cb);
                    c_tab[row.idx] = int'(row.cc);
                    d_tab[row.idx] = int'(row.cd);
                end
            end
        end
        else
        begin
            if (row.typed)
            begin
                r.value  = row.tv;
                r.region = row.tr;
                r.sat    = 1'b0;
            end
            else
                r = spline_value(row.q);
            pending_values.push_back(r);
        end
    endfunction

    // ---- stimulus rows ----

    function automatic stim_row_t wr_row(logic [4:0] k, logic [31:0] kt, logic [31:0] a,
                                         logic [31:0] b, logic [31:0] c, logic [31:0] d);
        stim_row_t r;
        r.kind  = ROW_BEAT;
        r.act   = ACTION_WRITE;
        r.idx   = k;
        r.knot  = kt;
        r.ca    = a;
        r.cb    = b;
        r.cc    = c;
        r.cd    = d;
        r.q     = $urandom;
        r.typed = 1'b0;
        r.tv    = '0;
        r.tr    = REGION_INSIDE;
        return r;
    endfunction

    function automatic stim_row_t ev_row(logic [31:0] q);
        stim_row_t r;
        r       = wr_row(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
                         $urandom, $urandom);
        r.act   = ACTION_EVAL;
        r.q     = q;
        return r;
    endfunction

    function automatic stim_row_t ev_first(logic [31:0] q, logic [31:0] v);
        stim_row_t r;
        r       = ev_row(q);
        r.typed = 1'b1;
        r.tv    = v;
        r.tr    = REGION_FIRST;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [4:0] v);
        stim_row_t r;
        r      = wr_row(v, '0, '0, '0, '0, '0);
        r.kind = ROW_CFG;
        return r;
    endfunction

    function automatic stim_row_t load_row(logic [4:0] first, logic [31:0] step);
        stim_row_t r;
        r      = wr_row(first, step, '0, '0, '0, '0);
        r.kind = ROW_LOAD;
        return r;
    endfunction

    function automatic logic [31:0] rand_coef(bit wild);
        if (wild)
            return $urandom;
        return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
    endfunction

    function automatic logic [31:0] pick_query();
        int     n;
        int     sel;
        longint lo;
        longint hi;
        longint span;
        n    = live_segments();
        lo   = knot_tab[0];
        hi   = knot_tab[n];
        span = hi - lo;
        sel  = $urandom_range(0, 99);
        if (sel < 60 && span > 0)
            return 32'(lo + longint'($urandom_range(0, 32'(span))));
        if (sel < 75)
            return knot_tab[$urandom_range(0, MAX_SEGMENTS)];
        if (sel < 80)
            return 32'(lo - longint'($urandom_range(0, 32'h0004_0000)));
        if (sel < 85)
            return 32'(hi + longint'($urandom_range(0, 32'h0004_0000)));
        return $urandom;
    endfunction

    function automatic stim_row_t noise_write(bit wild);
        logic [4:0]  k;
        logic [31:0] kt;
        if ($urandom_range(0, 6) == 0)
            k = 5'($urandom_range(17, 31));
        else
            k = 5'($urandom_range(0, MAX_SEGMENTS));
        if (k <= MAX_SEGMENTS && $urandom_range(0, 1) == 1)
            kt = 32'(knot_tab[k] + int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000);
        else
            kt = $urandom;
        return wr_row(k, kt, rand_coef(wild), rand_coef(wild), rand_coef(wild),
                      rand_coef(wild));
    endfunction

    // ---- driving ----

    task automatic send_beat(stim_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        action      <= row.act;
        entry_index <= row.idx;
        knot_time   <= row.knot;
        coef_const  <= row.ca;
        coef_linear <= row.cb;
        coef_square <= row.cc;
        coef_cube   <= row.cd;
        query_time  <= row.q;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        record_beat(row);
    endtask

    // drop valid, wait for every result, then allow for writes still in flight
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_segments(logic [4:0] v);
        settle();
        write_enable <= 1'b1;
        write_data   <= v;
        @(posedge clk);
        write_enable <= 1'b0;
        seg_reg = v;
    endtask

    // writes knots in rising order from entry first up to the last knot
    task automatic load_table(int first, logic [31:0] step_max, bit wild);
        int k;
        int kt;
        for (k = first; k <= MAX_SEGMENTS; k++)
        begin
            if (k == 0)
                kt = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            else
                kt = knot_tab[k-1] + int'($urandom_range(32'h4000, step_max));
            send_beat(wr_row(5'(k), kt, rand_coef(wild), rand_coef(wild), rand_coef(wild),
                             rand_coef(wild)));
        end
    endtask

    task automatic build_directed();
        localparam logic [31:0] A0 = 32'h0001_8000;
        dir_rows.push_back(wr_row(5'd0, 32'h0, A0, 32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000));
        dir_rows.push_back(wr_row(5'd1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                                  32'h0000_8000, 32'h0000_2000));
        // segment count still at its reset value here
        dir_rows.push_back(ev_first(32'h8000_0000, A0));
        dir_rows.push_back(ev_first(32'h0000_0000, A0));
        dir_rows.push_back(ev_row(32'h0000_8000));
        dir_rows.push_back(ev_row(32'h0001_0000));
        dir_rows.push_back(ev_row(32'h7FFF_FFFF));
        dir_rows.push_back(load_row(5'd2, 32'h0002_0000));
        dir_rows.push_back(cfg_row(5'd16));
        dir_rows.push_back(ev_row(32'h7FFF_FFFF));
        dir_rows.push_back(ev_row(32'h0001_2000));
        // last knot alone, coefficients dropped
        dir_rows.push_back(wr_row(5'd16, 32'h7FFF_FFFF, '1, '1, '1, '1));
        dir_rows.push_back(ev_row(32'h7FFF_FFFF));
        // out-of-range index must not alias onto the table
        dir_rows.push_back(wr_row(5'd17, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(ev_first(32'h8000_0000, A0));
        dir_rows.push_back(ev_row(32'h0001_2000));
        // unordered knot with maximum coefficients
        dir_rows.push_back(wr_row(5'd15, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_rows.push_back(wr_row(5'd31, 32'h0, '0, '0, '0, '0));
        dir_rows.push_back(ev_row(32'h7FFF_FFFF));
        dir_rows.push_back(ev_row(32'h4000_0000));
        dir_rows.push_back(wr_row(5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(ev_first(32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(ev_row(32'h8000_0001));
        dir_rows.push_back(cfg_row(5'd0));
        dir_rows.push_back(ev_row(32'h0000_0000));
        dir_rows.push_back(cfg_row(5'd31));
        // first and last knot rules both hold; first wins
        dir_rows.push_back(wr_row(5'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0));
        dir_rows.push_back(ev_first(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    endtask

    // ---- result side ----

    initial
    begin : stall_pattern
        int cyc;
        int mode;
        int hold;
        int holds_done;
        cyc        = 0;
        mode       = 0;
        hold       = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold == 0 && ((holds_done == 0 && results_seen >= 60) ||
                              (holds_done == 1 && results_seen >= 400)))
            begin
                hold = 300;
                holds_done++;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((cyc % 8) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        spline_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_values.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending, value %h", value));
            else
            begin
                want = pending_values.pop_front();
                if (value !== want.value)
                    report_mismatch($sformatf("value %h, want %h", value, want.value));
                if (region !== want.region)
                    report_mismatch($sformatf("region %0d, want %0d", region, want.region));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated %b, want %b", saturated, want.sat));
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---- main sequence ----

    initial
    begin
        int          p;
        int          i;
        int          counted;
        int          sel;
        int          waited;
        bit          wild;
        logic [4:0]  seg_sel;
        logic [31:0] step;
        stim_row_t   row;
        rst_n        = 1'b0;
        write_enable = 1'b0;
        write_data   = 5'd0;
        in_valid     = 1'b0;
        action       = ACTION_WRITE;
        entry_index  = 5'd0;
        knot_time    = '0;
        coef_const   = '0;
        coef_linear  = '0;
        coef_square  = '0;
        coef_cube    = '0;
        query_time   = '0;
        seg_reg      = 5'd1;
        mismatches   = 0;
        results_seen = 0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG:  set_segments(row.idx);
                ROW_LOAD: load_table(int'(row.idx), row.knot, 1'b0);
                default:  send_beat(row);
            endcase
        end

        for (p = 0; p < PHASES; p++)
        begin
            wild    = (p % 3 == 2);
            no_gaps = (p == 3 || p == 6);
            case (p % 4)
                0:       seg_sel = 5'($urandom_range(1, MAX_SEGMENTS));
                1:       seg_sel = 5'd16;
                2:       seg_sel = 5'd1;
                default: seg_sel = 5'($urandom_range(0, 31));
            endcase
            set_segments(seg_sel);
            if (wild)
                step = 32'h0100_0000;
            else
                step = (p % 2 == 1) ? 32'h0008_0000 : 32'h0002_0000;
            load_table(0, step, wild);
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    settle();
                else if (sel < 12)
                begin
                    row = noise_write(wild);
                    if (row.idx <= MAX_SEGMENTS)
                        counted++;
                    send_beat(row);
                end
                else
                begin
                    send_beat(ev_row(pick_query()));
                    counted++;
                end
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (pending_values.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_values.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_values.size()));
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: clamped_spline_evaluator_top.f
design/csev_pkg.sv
design/csev_ram.sv
design/csev_front.sv
design/csev_back.sv
design/clamped_spline_evaluator_top.sv
design/csev_checker.sv
sim/tb_top.sv
